/* src/stl_binary_record_parser_defines.svh */
// Assertion macros for the binary STL record parser.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef STL_BINARY_RECORD_PARSER_DEFINES_SVH
`define STL_BINARY_RECORD_PARSER_DEFINES_SVH

// Same-cycle implication check.
`define STLBRP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stlbrp: same-cycle check failed");

// Next-cycle implication check.
`define STLBRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stlbrp: next-cycle check failed");

`endif

/* src/stlbrp_pkg.sv */
// Package for the binary STL record parser: transfer payload types, status codes,
// framing constants and the vertex byte locator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stlbrp_pkg;

   localparam int unsigned TRI_W    = 27;
   localparam int unsigned POS_W    = 33;
   localparam int unsigned VCNT_W   = 29;
   localparam int unsigned TCNT_W   = 28;
   localparam int unsigned OFS_W    = 6;
   localparam int unsigned CSR_AW   = 2;
   localparam int unsigned CSR_DW   = 32;

   localparam logic [TRI_W-1:0]  MAX_TRI_RESET = TRI_W'(100000000);
   localparam logic [POS_W-1:0]  POS_MAX       = {POS_W{1'b1}};
   localparam logic [VCNT_W-1:0] VCNT_MAX      = {VCNT_W{1'b1}};
   localparam logic [POS_W-1:0]  HEADER_BYTES  = POS_W'(80);
   localparam logic [POS_W-1:0]  DATA_START    = POS_W'(84);
   localparam logic [OFS_W-1:0]  RECORD_LAST   = OFS_W'(49);
   localparam logic [OFS_W-1:0]  VERTEX_FIRST  = OFS_W'(12);
   localparam logic [OFS_W-1:0]  VERTEX_END    = OFS_W'(48);
   localparam logic [3:0]        VERTEX_LAST   = 4'd11;
   localparam logic [7:0]        EXP_ONES      = 8'hFF;

   localparam logic [0:0] KIND_VERTEX = 1'b0;
   localparam logic [0:0] KIND_END    = 1'b1;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_TOO_SMALL = 3'd1;
   localparam logic [2:0] ST_BAD_COUNT = 3'd2;
   localparam logic [2:0] ST_LEN_MISM  = 3'd3;
   localparam logic [2:0] ST_NONFINITE = 3'd4;

   localparam logic [0:0]        REG_MAX_TRI      = 1'b0;
   localparam logic [CSR_AW-1:0] REG_MAX_TRI_ADDR = CSR_AW'({REG_MAX_TRI, 2'b00});

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_final;
   } req_data_type;

   typedef struct packed {
      logic [0:0]        kind;
      logic [31:0]       x_bits;
      logic [31:0]       y_bits;
      logic [31:0]       z_bits;
      logic [VCNT_W-1:0] vertex_number;
      logic [2:0]        status;
      logic [31:0]       triangle_total;
      logic [TRI_W-1:0]  bad_triangle;
   } rsp_data_type;

   // byte location inside the current 12-byte vertex, for record offsets 12..47
   function automatic logic [3:0] vertex_loc(input logic [OFS_W-1:0] ofs);
      logic [OFS_W-1:0] d;
      d = ofs - VERTEX_FIRST;
      if (d >= OFS_W'(24)) begin
         d = d - OFS_W'(24);
      end else if (d >= OFS_W'(12)) begin
         d = d - OFS_W'(12);
      end
      return d[3:0];
   endfunction

endpackage

`default_nettype wire

/* src/stl_binary_record_parser.sv */
// Binary STL record parser: takes one file byte per transfer and emits one transfer per
// completed vertex (raw x/y/z float bits with a running vertex number) and one end
// transfer on the byte flagged final, whose status reports too small, count above
// max_triangles, length not 84 + 50 * count, or a non-finite vertex (first triangle
// kept). One byte is accepted every clock while req_stall is low; a result is registered
// and offered on the cycle after its byte is taken. The only back-pressure is the single
// result register: while it holds a result and rsp_stall is high, req_stall is high. Register
// 0 at byte address 0 (csr port) sets max_triangles; write it only while the stream is idle.
// Depends on stlbrp_pkg and stl_binary_record_parser_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "stl_binary_record_parser_defines.svh"

module stl_binary_record_parser import stlbrp_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire req_data_type       req_data,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      rsp_data_type       rsp_data,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [CSR_AW-1:0]  csr_paddr,
   input  wire logic [CSR_DW-1:0]  csr_pwdata,
   output      logic [CSR_DW-1:0]  csr_prdata,
   output      logic               csr_pready
);

   logic [TRI_W-1:0]       max_tri_ff;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [31:0]            count_ff, count_in;
   logic [OFS_W-1:0]       ofs_ff, ofs_in;
   logic [2:0][31:0]       coord_ff, coord_in;
   logic [VCNT_W-1:0]      vcnt_ff, vcnt_in;
   logic [TCNT_W-1:0]      tcnt_ff, tcnt_in;
   logic [1:0]             mod3_ff, mod3_in;
   logic                   nonfin_ff, nonfin_in;
   logic [TRI_W-1:0]       bad_tri_ff, bad_tri_in;
   logic [POS_W-1:0]       exp_len_ff, exp_len_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_data_type           rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic                   csr_write;
   logic                   vertex_done;
   logic                   any_bad;
   logic                   len_mism;
   logic [3:0]             loc;
   logic [2:0]             status;
   logic [TRI_W-1:0]       cnt_lo;

   assign accept     = req_valid && !req_stall;
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == REG_MAX_TRI_ADDR) ?
                       {{(CSR_DW-TRI_W){1'b0}}, max_tri_ff} : '0;

   // expected file length from the assembled count; valid two bytes after the count
   assign cnt_lo     = count_ff[TRI_W-1:0];
   assign exp_len_in = DATA_START + {1'b0, cnt_lo, 5'b0} + {2'b0, cnt_lo, 4'b0}
                     + {5'b0, cnt_lo, 1'b0};

   always_comb begin
      pos_in      = pos_ff;
      count_in    = count_ff;
      ofs_in      = ofs_ff;
      coord_in    = coord_ff;
      vcnt_in     = vcnt_ff;
      tcnt_in     = tcnt_ff;
      mod3_in     = mod3_ff;
      nonfin_in   = nonfin_ff;
      bad_tri_in  = bad_tri_ff;
      vertex_done = 1'b0;
      any_bad     = 1'b0;
      len_mism    = 1'b0;
      status      = ST_OK;
      loc         = vertex_loc(ofs_ff);
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (accept) begin
         if (pos_ff >= HEADER_BYTES && pos_ff < DATA_START) begin
            count_in[8*pos_ff[1:0] +: 8] = req_data.data_byte;
         end else if (pos_ff >= DATA_START) begin
            if (ofs_ff >= VERTEX_FIRST && ofs_ff < VERTEX_END) begin
               coord_in[loc[3:2]][8*loc[1:0] +: 8] = req_data.data_byte;
               vertex_done = (loc == VERTEX_LAST);
            end
            ofs_in = (ofs_ff == RECORD_LAST) ? '0 : ofs_ff + OFS_W'(1);
         end
         if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + POS_W'(1);
         end

         if (pos_ff == DATA_START - POS_W'(1)) begin
            len_mism = (count_in != 32'd0);
         end else if (pos_ff == DATA_START) begin
            len_mism = 1'b1;
         end else begin
            len_mism = (pos_in != exp_len_ff);
         end

         if (pos_in < DATA_START) begin
            status = ST_TOO_SMALL;
         end else if (count_in > {{(32-TRI_W){1'b0}}, max_tri_ff}) begin
            status = ST_BAD_COUNT;
         end else if (len_mism) begin
            status = ST_LEN_MISM;
         end else if (nonfin_ff) begin
            status = ST_NONFINITE;
         end

         any_bad = (coord_in[0][30:23] == EXP_ONES) || (coord_in[1][30:23] == EXP_ONES)
                || (coord_in[2][30:23] == EXP_ONES);

         if (req_data.is_final) begin
            rsp_valid_in               = 1'b1;
            rsp_data_in                = '0;
            rsp_data_in.kind           = KIND_END;
            rsp_data_in.status         = status;
            rsp_data_in.triangle_total = count_in;
            rsp_data_in.bad_triangle   = (status == ST_NONFINITE) ? bad_tri_ff : '0;
            pos_in     = '0;
            count_in   = '0;
            ofs_in     = '0;
            vcnt_in    = '0;
            tcnt_in    = '0;
            mod3_in    = '0;
            nonfin_in  = 1'b0;
            bad_tri_in = '0;
         end else if (vertex_done) begin
            rsp_valid_in              = 1'b1;
            rsp_data_in               = '0;
            rsp_data_in.kind          = KIND_VERTEX;
            rsp_data_in.x_bits        = coord_in[0];
            rsp_data_in.y_bits        = coord_in[1];
            rsp_data_in.z_bits        = coord_in[2];
            rsp_data_in.vertex_number = vcnt_ff;
            if (!nonfin_ff && any_bad) begin
               nonfin_in  = 1'b1;
               bad_tri_in = tcnt_ff[TRI_W-1:0];
            end
            if (vcnt_ff != VCNT_MAX) begin
               vcnt_in = vcnt_ff + VCNT_W'(1);
               if (mod3_ff == 2'd2) begin
                  mod3_in = 2'd0;
                  tcnt_in = tcnt_ff + TCNT_W'(1);
               end else begin
                  mod3_in = mod3_ff + 2'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_tri_ff   <= MAX_TRI_RESET;
         pos_ff       <= '0;
         count_ff     <= '0;
         ofs_ff       <= '0;
         vcnt_ff      <= '0;
         tcnt_ff      <= '0;
         mod3_ff      <= '0;
         nonfin_ff    <= 1'b0;
         bad_tri_ff   <= '0;
         exp_len_ff   <= DATA_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            max_tri_ff <= csr_pwdata[TRI_W-1:0];
         end
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         ofs_ff       <= ofs_in;
         vcnt_ff      <= vcnt_in;
         tcnt_ff      <= tcnt_in;
         mod3_ff      <= mod3_in;
         nonfin_ff    <= nonfin_in;
         bad_tri_ff   <= bad_tri_in;
         exp_len_ff   <= exp_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      coord_ff    <= coord_in;
      rsp_data_ff <= rsp_data_in;
   end

   `STLBRP_ASSERT_NEXT(a_final_clears, clock, reset, accept && req_data.is_final,
      pos_ff == '0 && vcnt_ff == '0 && ofs_ff == '0 && !nonfin_ff)
   `STLBRP_ASSERT_NEXT(a_final_ends, clock, reset, accept && req_data.is_final,
      rsp_valid_ff && rsp_data_ff.kind == KIND_END)
   `STLBRP_ASSERT_NEXT(a_nonfin_sticky, clock, reset,
      nonfin_ff && !(accept && req_data.is_final), nonfin_ff)
   `STLBRP_ASSERT_NOW(a_tri_track, clock, reset, 1'b1,
      {1'b0, vcnt_ff} == {tcnt_ff, 1'b0} + {1'b0, tcnt_ff} + {28'd0, mod3_ff})

endmodule

`default_nettype wire
